FILE: src/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants, state type and control structs of the modular
// exponentiation engine.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int DATA_W             = 32;
    localparam int CFG_IDX_W          = 8;
    localparam int DEFAULT_WORD_WIDTH = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } modexp_state_t;

    typedef struct packed {
        logic start;
    } mm_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

FILE: src/modexp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_cell
// One bit slice of the shift-add modular multiplier: holds one remainder bit,
// forms 2R + A, 2R + A - M and 2R + A - 2M with ripple from its neighbor.
// ----------------------------------------------------------------------------
module modexp_cell
    import modexp_pkg::*;
(
    input  logic clk,
    input  logic clr,
    input  logic en,
    input  logic r_lo,
    input  logic a_bit,
    input  logic m_bit,
    input  logic m2_bit,
    input  logic add_sel,
    input  logic use_d1,
    input  logic use_d2,
    input  logic c_in,
    input  logic b1_in,
    input  logic b2_in,
    output logic c_out,
    output logic b1_out,
    output logic b2_out,
    output logic r_bit
);

    logic r_reg;
    logic r_next;
    logic addend;
    logic t_bit;
    logic d1_bit;
    logic d2_bit;

    always_comb
    begin
        addend = add_sel & a_bit;
        t_bit  = r_lo ^ addend ^ c_in;
        c_out  = (r_lo & addend) | (r_lo & c_in) | (addend & c_in);
        d1_bit = t_bit ^ m_bit ^ b1_in;
        b1_out = (~t_bit & m_bit) | (~t_bit & b1_in) | (m_bit & b1_in);
        d2_bit = t_bit ^ m2_bit ^ b2_in;
        b2_out = (~t_bit & m2_bit) | (~t_bit & b2_in) | (m2_bit & b2_in);
        if (clr)
        begin
            r_next = 1'b0;
        end
        else if (en)
        begin
            r_next = use_d2 ? d2_bit : (use_d1 ? d1_bit : t_bit);
        end
        else
        begin
            r_next = r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign r_bit = r_reg;

endmodule

FILE: src/modexp_mm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_mm
// Interleaved modular multiplier: a row of bit cells, one multiplier bit per
// cycle from the top.
// ----------------------------------------------------------------------------
module modexp_mm
    import modexp_pkg::*;
#(
    parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mm_ctrl_t              ctrl,
    input  logic [WORD_WIDTH-1:0] a,
    input  logic [WORD_WIDTH-1:0] b,
    input  logic [WORD_WIDTH-1:0] m,
    output mm_stat_t              stat,
    output logic [WORD_WIDTH-1:0] result
);

    localparam int NC    = WORD_WIDTH + 2;
    localparam int CNT_W = $clog2(WORD_WIDTH + 1);

    logic [WORD_WIDTH-1:0] b_reg;
    logic [WORD_WIDTH-1:0] b_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;

    logic [NC-1:0] r_all;
    logic [NC-1:0] r_sh;
    logic [NC-1:0] a_ext;
    logic [NC-1:0] m_ext;
    logic [NC-1:0] m2_ext;
    logic [NC:0]   c_ch;
    logic [NC:0]   b1_ch;
    logic [NC:0]   b2_ch;
    logic          use_d1;
    logic          use_d2;

    assign r_sh   = {r_all[NC-2:0], 1'b0};
    assign a_ext  = {2'b00, a};
    assign m_ext  = {2'b00, m};
    assign m2_ext = {1'b0, m, 1'b0};
    assign c_ch[0]  = 1'b0;
    assign b1_ch[0] = 1'b0;
    assign b2_ch[0] = 1'b0;
    // borrow out of the top slice means the sum is below M (or 2M)
    assign use_d1 = ~b1_ch[NC];
    assign use_d2 = ~b2_ch[NC];

    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        modexp_cell u_cell (
            .clk     (clk),
            .clr     (ctrl.start),
            .en      (busy_reg),
            .r_lo    (r_sh[j]),
            .a_bit   (a_ext[j]),
            .m_bit   (m_ext[j]),
            .m2_bit  (m2_ext[j]),
            .add_sel (b_reg[WORD_WIDTH-1]),
            .use_d1  (use_d1),
            .use_d2  (use_d2),
            .c_in    (c_ch[j]),
            .b1_in   (b1_ch[j]),
            .b2_in   (b2_ch[j]),
            .c_out   (c_ch[j+1]),
            .b1_out  (b1_ch[j+1]),
            .b2_out  (b2_ch[j+1]),
            .r_bit   (r_all[j])
        );
    end

    always_comb
    begin
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            b_next    = b;
            cnt_next  = CNT_W'(WORD_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            b_next   = {b_reg[WORD_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_all[WORD_WIDTH-1:0];

endmodule

FILE: src/modular_exponentiation.sv
`timescale 1ns / 1ps
// Each clear exponent bit skips one multiply.
// One word at a time: the single bit-cell multiplier row, one multiplier bit
// per cycle, serves every step of a word.
// Reset: asynchronous, active low; exponent clears to 0, modulus to 1, the
// engine idles and no result word is pending.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left binary modular exponentiation over a shared shift-add
// modular multiplier built as a chain of bit cells.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_W-1:0]    message_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    power_value
);

    localparam int BIT_W = $clog2(WORD_WIDTH);

    // key registers, always writable
    logic [WORD_WIDTH-1:0] exponent_reg;
    logic [WORD_WIDTH-1:0] modulus_reg;
    logic [WORD_WIDTH-1:0] cfg_word;

    modexp_state_t         state_reg;
    modexp_state_t         state_next;
    logic                  launch_reg;
    logic                  launch_next;
    logic [WORD_WIDTH-1:0] msg_reg;
    logic [WORD_WIDTH-1:0] msg_next;
    logic [WORD_WIDTH-1:0] acc_reg;
    logic [WORD_WIDTH-1:0] acc_next;
    logic [WORD_WIDTH-1:0] pw_reg;
    logic [WORD_WIDTH-1:0] pw_next;
    logic [WORD_WIDTH-1:0] exp_reg;
    logic [WORD_WIDTH-1:0] exp_next;
    logic [BIT_W-1:0]      bit_reg;
    logic [BIT_W-1:0]      bit_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_W-1:0]     power_reg;
    logic [DATA_W-1:0]     power_next;

    mm_ctrl_t              mm_ctrl;
    mm_stat_t              mm_stat;
    logic [WORD_WIDTH-1:0] mm_a;
    logic [WORD_WIDTH-1:0] mm_b;
    logic [WORD_WIDTH-1:0] mm_res;
    logic                  in_fire;
    logic                  out_free;

    assign cfg_ready = 1'b1;
    assign cfg_word  = cfg_data[WORD_WIDTH-1:0];

    // Drop modulus writes of zero and writes to unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= '0;
            modulus_reg  <= WORD_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_word;
                REG_MODULUS:
                begin
                    if (cfg_word != '0)
                    begin
                        modulus_reg <= cfg_word;
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Operand select: reduce the base as 1 * msg, multiply acc by the base
    // power, square the base power. The A operand is always below or equal
    // to the modulus, which keeps 2R + A under 3M.
    always_comb
    begin
        case (state_reg)
            ST_REDUCE:
            begin
                mm_a = WORD_WIDTH'(1);
                mm_b = msg_reg;
            end
            ST_MUL:
            begin
                mm_a = pw_reg;
                mm_b = acc_reg;
            end
            default:
            begin
                mm_a = pw_reg;
                mm_b = pw_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = ST_REDUCE;
                    launch_next = 1'b1;
                end
            end
            ST_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    state_next  = exp_reg[0] ? ST_MUL : ST_SQR;
                    launch_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    state_next  = ST_SQR;
                    launch_next = 1'b1;
                end
            end
            ST_SQR:
            begin
                if (mm_stat.done)
                begin
                    if (bit_reg == BIT_W'(WORD_WIDTH - 1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next  = exp_reg[1] ? ST_MUL : ST_SQR;
                        launch_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        msg_next       = msg_reg;
        acc_next       = acc_reg;
        pw_next        = pw_reg;
        exp_next       = exp_reg;
        bit_next       = bit_reg;
        power_next     = power_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    msg_next = message_value[WORD_WIDTH-1:0];
                    acc_next = WORD_WIDTH'(1);
                    exp_next = exponent_reg;
                    bit_next = '0;
                end
            end
            ST_REDUCE:
            begin
                if (mm_stat.done)
                begin
                    pw_next = mm_res;
                end
            end
            ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_res;
                end
            end
            ST_SQR:
            begin
                if (mm_stat.done)
                begin
                    pw_next  = mm_res;
                    exp_next = exp_reg >> 1;
                    bit_next = bit_reg + BIT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    power_next     = DATA_W'(acc_reg);
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        msg_reg   <= msg_next;
        acc_reg   <= acc_next;
        pw_reg    <= pw_next;
        exp_reg   <= exp_next;
        power_reg <= power_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign mm_ctrl.start = launch_reg;

    modexp_mm #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mm (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mm_ctrl),
        .a      (mm_a),
        .b      (mm_b),
        .m      (modulus_reg),
        .stat   (mm_stat),
        .result (mm_res)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign power_value = power_reg;

endmodule

FILE: src/modexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker
// Port-level checks of the modular exponentiation engine.
// ----------------------------------------------------------------------------
module modexp_checker
    import modexp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_ready,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] power_value
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("engine took a second word while busy");

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result word shown while engine not idle");

    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_value))
        else $error("stalled result word changed");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .power_value (power_value)
);
